@@ rtl/core/lbc_pkg.sv @@
package lbc_pkg;

    localparam int MAX_ENTRIES_DEF = 64;
    localparam int BLOCK_WORDS_DEF = 32;

    localparam int KEY_W   = 12;
    localparam int STAMP_W = 32;
    localparam int WORD_W  = 64;
    localparam int EIU_W   = 7;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_UNDEF  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES = 2'd1;

    localparam logic [EIU_W-1:0]   EIU_RESET = 7'd64;
    localparam logic [STAMP_W-1:0] CLOCK_MAX = 32'hFFFF_FFFF;

endpackage

@@ rtl/core/lbc_ram.sv @@
module lbc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/lbc_scan.sv @@
module lbc_scan
    import lbc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           cmp_valid,
    input  logic [$clog2(MAX_ENTRIES)-1:0] cmp_idx,
    input  logic [KEY_W-1:0]               key,
    input  logic [KEY_W-1:0]               tag,
    input  logic [STAMP_W-1:0]             stamp,
    output logic                           hit,
    output logic [$clog2(MAX_ENTRIES)-1:0] hit_idx,
    output logic [$clog2(MAX_ENTRIES)-1:0] min_idx
);

    localparam int EW = $clog2(MAX_ENTRIES);

    logic               hit_reg, hit_next;
    logic [EW-1:0]      hit_idx_reg, hit_idx_next;
    logic [EW-1:0]      min_idx_reg, min_idx_next;
    logic [STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic               have_min_reg, have_min_next;

    always_comb
    begin
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        min_idx_next   = min_idx_reg;
        min_stamp_next = min_stamp_reg;
        have_min_next  = have_min_reg;
        if (start)
        begin
            hit_next      = 1'b0;
            have_min_next = 1'b0;
            min_idx_next  = '0;
        end
        else if (cmp_valid)
        begin
            if (tag == key)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx;
            end
            // strict compare keeps the lowest index among equal stamps
            if (!have_min_reg || (stamp < min_stamp_reg))
            begin
                have_min_next  = 1'b1;
                min_stamp_next = stamp;
                min_idx_next   = cmp_idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            have_min_reg <= 1'b0;
        end
        else
        begin
            hit_reg      <= hit_next;
            have_min_reg <= have_min_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_idx_reg   <= hit_idx_next;
        min_idx_reg   <= min_idx_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign hit     = hit_reg;
    assign hit_idx = hit_idx_reg;
    assign min_idx = min_idx_reg;

endmodule

@@ rtl/core/lru_block_cache_top.sv @@
// lookup hit: tag scan and decide, then each word is read from the data store and registered
// insert/update on the last word: tag scan and decide, then each staged word is copied
// the tag and stamp scan reads one entry per cycle through a single compare unit
// gathering words are taken in idle; a lookup miss on a disabled or empty cache skips the scan
// reset is asynchronous active low: cache disabled, store empty, clock and staging zero
module lru_block_cache_top
    import lbc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [EIU_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           opcode,
    input  logic [3:0]           disk_number,
    input  logic [7:0]           block_number,
    input  logic [WORD_W-1:0]    data_word,
    input  logic                 last_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 status,
    output logic [WORD_W-1:0]    read_word,
    output logic                 last_result
);

    localparam int EW  = $clog2(MAX_ENTRIES);
    localparam int FW  = $clog2(MAX_ENTRIES + 1);
    localparam int SAW = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
    localparam int SW  = $clog2(BLOCK_WORDS + 1);
    localparam int DAW = $clog2(MAX_ENTRIES * BLOCK_WORDS);
    localparam int CW  = (FW > EIU_W) ? FW : EIU_W;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_SCAN      = 4'd1;
    localparam logic [3:0] S_DECIDE    = 4'd2;
    localparam logic [3:0] S_STREAM_RD = 4'd3;
    localparam logic [3:0] S_STREAM_LD = 4'd4;
    localparam logic [3:0] S_COPY_RD   = 4'd5;
    localparam logic [3:0] S_COPY_WR   = 4'd6;
    localparam logic [3:0] S_OUT       = 4'd7;

    logic [3:0]         state_reg, state_next;
    logic               enable_reg, enable_next;
    logic [EIU_W-1:0]   eiu_reg, eiu_next;
    logic [FW-1:0]      fill_reg, fill_next;
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [SW-1:0]      stage_idx_reg, stage_idx_next;
    logic [FW-1:0]      scan_reg, scan_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [EW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [EW-1:0]      target_reg, target_next;
    logic [SAW-1:0]     k_reg, k_next;
    logic               out_valid_reg, out_valid_next;
    logic               more_reg, more_next;
    logic [1:0]         op_reg, op_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               status_reg, status_next;
    logic [WORD_W-1:0]  word_reg, word_next;
    logic               last_reg, last_next;

    logic               scan_start;
    logic               hit;
    logic [EW-1:0]      hit_idx;
    logic [EW-1:0]      min_idx;
    logic [KEY_W-1:0]   tag_rdata;
    logic [STAMP_W-1:0] stamp_rdata;
    logic [WORD_W-1:0]  stage_rdata;
    logic [WORD_W-1:0]  data_rdata;

    logic               tag_we;
    logic               stamp_we;
    logic [EW-1:0]      meta_waddr;
    logic               stage_we;
    logic [SAW-1:0]     stage_raddr;
    logic               data_we;
    logic [DAW-1:0]     data_addr;

    logic [CW-1:0]      active_n;
    logic               full;
    logic [STAMP_W-1:0] clock_tick;
    logic               in_acc;
    logic               cfg_acc;
    logic               k_last;

    always_comb
    begin
        if (eiu_reg < 7'd2)
        begin
            active_n = CW'(2);
        end
        else if (CW'(eiu_reg) > CW'(MAX_ENTRIES))
        begin
            active_n = CW'(MAX_ENTRIES);
        end
        else
        begin
            active_n = CW'(eiu_reg);
        end
    end

    assign full       = CW'(fill_reg) >= active_n;
    assign clock_tick = (clock_reg == CLOCK_MAX) ? clock_reg : clock_reg + 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign cfg_ready  = 1'b1;
    assign in_acc     = in_valid && in_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign k_last     = (k_reg == SAW'(BLOCK_WORDS - 1));
    assign data_addr  = DAW'(target_reg) * DAW'(BLOCK_WORDS) + DAW'(k_reg);
    assign meta_waddr = target_next;
    assign stage_raddr = k_reg;

    always_comb
    begin
        state_next     = state_reg;
        enable_next    = enable_reg;
        eiu_next       = eiu_reg;
        fill_next      = fill_reg;
        clock_next     = clock_reg;
        stage_idx_next = stage_idx_reg;
        scan_next      = scan_reg;
        cmp_vld_next   = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        target_next    = target_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        more_next      = more_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        word_next      = word_reg;
        last_next      = last_reg;
        scan_start     = 1'b0;
        tag_we         = 1'b0;
        stamp_we       = 1'b0;
        stage_we       = 1'b0;
        data_we        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = opcode;
                    key_next = {disk_number, block_number};
                    scan_next = '0;
                    // default answer: one failure transaction
                    status_next = 1'b1;
                    word_next   = '0;
                    last_next   = 1'b1;
                    more_next   = 1'b0;
                    if (opcode == OP_LOOKUP)
                    begin
                        if (!enable_reg || (fill_reg == '0))
                        begin
                            out_valid_next = 1'b1;
                            state_next     = S_OUT;
                        end
                        else
                        begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    else if ((opcode == OP_INSERT) || (opcode == OP_UPDATE))
                    begin
                        if (stage_idx_reg != SW'(BLOCK_WORDS))
                        begin
                            stage_we       = 1'b1;
                            stage_idx_next = stage_idx_reg + 1'b1;
                        end
                        if (last_word)
                        begin
                            if (!enable_reg)
                            begin
                                stage_idx_next = '0;
                                out_valid_next = 1'b1;
                                state_next     = S_OUT;
                            end
                            else
                            begin
                                scan_start = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_reg < fill_reg)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = scan_reg[EW-1:0];
                    scan_next    = scan_reg + 1'b1;
                end
                else if (!cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                k_next = '0;
                if (op_reg == OP_LOOKUP)
                begin
                    if (hit)
                    begin
                        clock_next  = clock_tick;
                        target_next = hit_idx;
                        stamp_we    = 1'b1;
                        state_next  = S_STREAM_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                end
                else if (op_reg == OP_UPDATE)
                begin
                    clock_next = clock_tick;
                    if (hit)
                    begin
                        target_next = hit_idx;
                        stamp_we    = 1'b1;
                        state_next  = S_COPY_RD;
                    end
                    else
                    begin
                        stage_idx_next = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        stage_idx_next = '0;
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        clock_next = clock_tick;
                        if (full)
                        begin
                            target_next = min_idx;
                        end
                        else
                        begin
                            target_next = fill_reg[EW-1:0];
                            fill_next   = fill_reg + 1'b1;
                        end
                        tag_we     = 1'b1;
                        stamp_we   = 1'b1;
                        state_next = S_COPY_RD;
                    end
                end
            end
            S_COPY_RD:
            begin
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                data_we = 1'b1;
                if (k_last)
                begin
                    stage_idx_next = '0;
                    status_next    = 1'b0;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_COPY_RD;
                end
            end
            S_STREAM_RD:
            begin
                state_next = S_STREAM_LD;
            end
            S_STREAM_LD:
            begin
                status_next    = 1'b0;
                word_next      = data_rdata;
                last_next      = k_last;
                more_next      = !k_last;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    if (more_reg)
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_STREAM_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a write to the enable or entries register empties the store
        if (cfg_acc && ((cfg_index == CFG_ENABLE) || (cfg_index == CFG_ENTRIES)))
        begin
            if (cfg_index == CFG_ENABLE)
            begin
                enable_next = cfg_data[0];
            end
            else
            begin
                eiu_next = cfg_data;
            end
            fill_next      = '0;
            clock_next     = '0;
            stage_idx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            enable_reg    <= 1'b0;
            eiu_reg       <= EIU_RESET;
            fill_reg      <= '0;
            clock_reg     <= '0;
            stage_idx_reg <= '0;
            scan_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            more_reg      <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            enable_reg    <= enable_next;
            eiu_reg       <= eiu_next;
            fill_reg      <= fill_next;
            clock_reg     <= clock_next;
            stage_idx_reg <= stage_idx_next;
            scan_reg      <= scan_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
            more_reg      <= more_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        target_reg  <= target_next;
        op_reg      <= op_next;
        key_reg     <= key_next;
        status_reg  <= status_next;
        word_reg    <= word_next;
        last_reg    <= last_next;
    end

    lbc_scan #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (scan_start),
        .cmp_valid(cmp_vld_reg),
        .cmp_idx  (cmp_idx_reg),
        .key      (key_reg),
        .tag      (tag_rdata),
        .stamp    (stamp_rdata),
        .hit      (hit),
        .hit_idx  (hit_idx),
        .min_idx  (min_idx)
    );

    lbc_ram #(
        .WIDTH(KEY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_tag_ram (
        .clk  (clk),
        .we   (tag_we),
        .waddr(meta_waddr),
        .wdata(key_reg),
        .raddr(scan_reg[EW-1:0]),
        .rdata(tag_rdata)
    );

    lbc_ram #(
        .WIDTH(STAMP_W),
        .DEPTH(MAX_ENTRIES)
    ) u_stamp_ram (
        .clk  (clk),
        .we   (stamp_we),
        .waddr(meta_waddr),
        .wdata(clock_next),
        .raddr(scan_reg[EW-1:0]),
        .rdata(stamp_rdata)
    );

    lbc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(BLOCK_WORDS)
    ) u_stage_ram (
        .clk  (clk),
        .we   (stage_we),
        .waddr(stage_idx_reg[SAW-1:0]),
        .wdata(data_word),
        .raddr(stage_raddr),
        .rdata(stage_rdata)
    );

    // words past the gathered count read as zero
    lbc_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MAX_ENTRIES * BLOCK_WORDS)
    ) u_data_ram (
        .clk  (clk),
        .we   (data_we),
        .waddr(data_addr),
        .wdata((SW'(k_reg) < stage_idx_reg) ? stage_rdata : '0),
        .raddr(data_addr),
        .rdata(data_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_word   = word_reg;
    assign last_result = last_reg;

`ifndef NO_ASSERTIONS
    a_out_only_in_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_OUT))
        else $error("result pending outside output state");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(fill_reg) <= CW'(MAX_ENTRIES))
        else $error("fill count beyond store size");

    a_stage_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        stage_idx_reg <= SW'(BLOCK_WORDS))
        else $error("staging index beyond block size");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_result) |=> (state_reg == S_IDLE))
        else $error("final transaction did not return to idle");

    a_lookup_no_fill_change: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DECIDE) && (op_reg != OP_INSERT) && !cfg_acc)
        |=> (fill_reg == $past(fill_reg)))
        else $error("fill count changed outside insert");
`endif

endmodule
